/* sv/imfwd_pkg.sv */
// ----------------------------------------------------------------------------
// imfwd_pkg
// Shared constants, codes and control types for the multicast forward table.
// ----------------------------------------------------------------------------
package imfwd_pkg;

  localparam int NUM_PORTS_DEF    = 16;
  localparam int GROUP_BITS_DEF   = 10;
  localparam int PORT_FIELD_LIMIT = 16;

  localparam int CMD_W    = 3;
  localparam int ADDR_W   = 32;
  localparam int PORT_W   = 4;
  localparam int HOP_W    = 8;
  localparam int HANDLE_W = 16;
  localparam int ACT_W    = 2;

  // input beat layout
  localparam int IN_CMD_LSB    = 0;
  localparam int IN_ADDR_LSB   = IN_CMD_LSB + CMD_W;
  localparam int IN_PORT_LSB   = IN_ADDR_LSB + ADDR_W;
  localparam int IN_HOP_LSB    = IN_PORT_LSB + PORT_W;
  localparam int IN_HANDLE_LSB = IN_HOP_LSB + HOP_W;
  localparam int IN_USED_W     = IN_HANDLE_LSB + HANDLE_W;
  localparam int IN_DATA_W     = ((IN_USED_W + 7) / 8) * 8;

  // output beat layout
  localparam int OUT_ACT_LSB    = 0;
  localparam int OUT_PORT_LSB   = OUT_ACT_LSB + ACT_W;
  localparam int OUT_HANDLE_LSB = OUT_PORT_LSB + PORT_W;
  localparam int OUT_USED_W     = OUT_HANDLE_LSB + HANDLE_W;
  localparam int OUT_DATA_W     = ((OUT_USED_W + 7) / 8) * 8;

  localparam logic [3:0] MCAST_PREFIX = 4'hE;

  localparam logic [CMD_W-1:0] CMD_RECEIVE     = 3'd0;
  localparam logic [CMD_W-1:0] CMD_SEND        = 3'd1;
  localparam logic [CMD_W-1:0] CMD_JOIN        = 3'd2;
  localparam logic [CMD_W-1:0] CMD_LEAVE       = 3'd3;
  localparam logic [CMD_W-1:0] CMD_LOCAL_JOIN  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_LOCAL_LEAVE = 3'd5;

  localparam logic [ACT_W-1:0] ACT_DELIVER  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_TRANSMIT = 2'd1;
  localparam logic [ACT_W-1:0] ACT_ERROR    = 2'd2;

  typedef struct packed {
    logic clear;
    logic accept;
    logic exec;
    logic emit;
  } imfwd_ctl_t;

  typedef struct packed {
    logic clr_done;
    logic work_found;
    logic out_free;
    logic last_pick;
  } imfwd_sts_t;

endpackage

/* sv/imfwd_ctrl.sv */
// ----------------------------------------------------------------------------
// imfwd_ctrl
// Sequencer: table clear after reset, item accept, lookup and result emission.
// ----------------------------------------------------------------------------
module imfwd_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  imfwd_pkg::imfwd_sts_t sts,
  output imfwd_pkg::imfwd_ctl_t ctl
);
  import imfwd_pkg::*;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_EXEC  = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    s_tready   = 1'b0;
    case (state)
      ST_CLEAR: begin
        ctl.clear = 1'b1;
        if (sts.clr_done) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        s_tready   = 1'b1;
        ctl.accept = s_tvalid;
        if (s_tvalid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        ctl.exec   = 1'b1;
        state_next = sts.work_found ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        ctl.emit = sts.out_free;
        if (sts.out_free && sts.last_pick) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

/* sv/imfwd_dp.sv */
// ----------------------------------------------------------------------------
// imfwd_dp
// Group table memory, item registers, result selection and output register.
// ----------------------------------------------------------------------------
module imfwd_dp #(
  parameter int NUM_PORTS  = imfwd_pkg::NUM_PORTS_DEF,
  parameter int GROUP_BITS = imfwd_pkg::GROUP_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [imfwd_pkg::IN_DATA_W-1:0]     s_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [imfwd_pkg::OUT_DATA_W-1:0]    m_tdata,
  output logic                                m_tlast,
  input  imfwd_pkg::imfwd_ctl_t               ctl,
  output imfwd_pkg::imfwd_sts_t               sts
);
  import imfwd_pkg::*;

  localparam int MAP_W  = (NUM_PORTS < PORT_FIELD_LIMIT) ? NUM_PORTS : PORT_FIELD_LIMIT;
  localparam int DEPTH  = 1 << GROUP_BITS;
  localparam int WORD_W = MAP_W + 1 + PORT_W;
  localparam int VLD_B  = MAP_W;
  localparam int MP_LSB = MAP_W + 1;

  // table word: member port, member valid, port bitmap
  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rd_word;
  logic              wr_en;
  logic [GROUP_BITS-1:0] wr_addr;
  logic [WORD_W-1:0] wr_data;
  logic [GROUP_BITS-1:0] clr_addr;

  logic [CMD_W-1:0]      it_cmd;
  logic                  it_mcast;
  logic [GROUP_BITS-1:0] it_group;
  logic [PORT_W-1:0]     it_port;
  logic                  it_hop_nz;
  logic [HANDLE_W-1:0]   it_handle;

  logic [GROUP_BITS-1:0] in_group;

  logic              w_err;
  logic              w_snd;
  logic              w_loc;
  logic [MAP_W-1:0]  w_mask;
  logic [PORT_W-1:0] w_mport;

  logic              x_err;
  logic              x_snd;
  logic              x_loc;
  logic [MAP_W-1:0]  x_mask;
  logic              x_wr;
  logic [WORD_W-1:0] x_word;

  logic [MAP_W-1:0]  rd_map;
  logic              rd_vld;
  logic [PORT_W-1:0] rd_mport;
  logic [MAP_W-1:0]  port_bit;

  logic [PORT_W-1:0] low_idx;
  logic [MAP_W-1:0]  mask_rest;
  logic [ACT_W-1:0]  pk_act;
  logic [PORT_W-1:0] pk_port;
  logic [HANDLE_W-1:0] pk_handle;
  logic              pk_last;

  assign in_group = s_tdata[IN_ADDR_LSB +: GROUP_BITS];

  assign rd_map   = rd_word[MAP_W-1:0];
  assign rd_vld   = rd_word[VLD_B];
  assign rd_mport = rd_word[MP_LSB +: PORT_W];
  assign port_bit = MAP_W'(1) << it_port;

  // clear sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (ctl.clear) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  assign sts.clr_done = &clr_addr;

  // item capture
  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      it_cmd    <= s_tdata[IN_CMD_LSB +: CMD_W];
      it_mcast  <= (s_tdata[IN_ADDR_LSB + ADDR_W - 4 +: 4] == MCAST_PREFIX);
      it_group  <= in_group;
      it_port   <= s_tdata[IN_PORT_LSB +: PORT_W];
      it_hop_nz <= |s_tdata[IN_HOP_LSB +: HOP_W];
      it_handle <= s_tdata[IN_HANDLE_LSB +: HANDLE_W];
    end
  end

  // lookup decode
  always_comb begin
    x_err  = 1'b0;
    x_snd  = 1'b0;
    x_loc  = 1'b0;
    x_mask = '0;
    x_wr   = 1'b0;
    x_word = rd_word;
    if (!it_mcast) begin
      x_err = (it_cmd >= CMD_JOIN) && (it_cmd <= CMD_LOCAL_LEAVE);
    end else begin
      case (it_cmd)
        CMD_RECEIVE: begin
          x_loc  = rd_vld;
          x_mask = it_hop_nz ? (rd_map & ~port_bit) : '0;
        end
        CMD_SEND: begin
          x_snd = rd_vld;
        end
        CMD_JOIN: begin
          x_wr              = 1'b1;
          x_word[MAP_W-1:0] = rd_map | port_bit;
        end
        CMD_LEAVE: begin
          x_wr              = 1'b1;
          x_word[MAP_W-1:0] = rd_map & ~port_bit;
        end
        CMD_LOCAL_JOIN: begin
          x_wr                     = 1'b1;
          x_word[VLD_B]            = 1'b1;
          x_word[MP_LSB +: PORT_W] = it_port;
        end
        CMD_LOCAL_LEAVE: begin
          x_wr                     = 1'b1;
          x_word[VLD_B]            = 1'b0;
          x_word[MP_LSB +: PORT_W] = '0;
        end
        default: begin
          x_wr = 1'b0;
        end
      endcase
    end
  end

  assign sts.work_found = x_err | x_snd | x_loc | (|x_mask);

  // table memory
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = it_group;
    wr_data = x_word;
    if (ctl.clear) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr;
      wr_data = '0;
    end else if (ctl.exec) begin
      wr_en = x_wr;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (ctl.accept) rd_word <= mem[in_group];
  end

  // pending work
  always_comb begin
    low_idx = '0;
    for (int i = MAP_W - 1; i >= 0; i--) begin
      if (w_mask[i]) low_idx = PORT_W'(i);
    end
  end

  assign mask_rest = w_mask & (w_mask - MAP_W'(1));

  always_comb begin
    pk_handle = it_handle;
    if (w_err) begin
      pk_act    = ACT_ERROR;
      pk_port   = '0;
      pk_handle = '0;
      pk_last   = 1'b1;
    end else if (w_snd) begin
      pk_act  = ACT_TRANSMIT;
      pk_port = w_mport;
      pk_last = 1'b1;
    end else if (w_loc) begin
      pk_act  = ACT_DELIVER;
      pk_port = it_port;
      pk_last = ~|w_mask;
    end else begin
      pk_act  = ACT_TRANSMIT;
      pk_port = low_idx;
      pk_last = ~|mask_rest;
    end
  end

  assign sts.last_pick = pk_last;

  always_ff @(posedge clk) begin
    if (ctl.exec) begin
      w_err   <= x_err;
      w_snd   <= x_snd;
      w_loc   <= x_loc;
      w_mask  <= x_mask;
      w_mport <= rd_mport;
    end else if (ctl.emit) begin
      if (w_err) begin
        w_err <= 1'b0;
      end else if (w_snd) begin
        w_snd <= 1'b0;
      end else if (w_loc) begin
        w_loc <= 1'b0;
      end else begin
        w_mask <= mask_rest;
      end
    end
  end

  // output register
  assign sts.out_free = ~m_tvalid | m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ctl.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      m_tdata <= OUT_DATA_W'({pk_handle, pk_port, pk_act});
      m_tlast <= pk_last;
    end
  end

endmodule

/* sv/ip_multicast_forward_table.sv */
// ----------------------------------------------------------------------------
// ip_multicast_forward_table
// Multicast group table: port bitmap and local membership per group, with
// per-packet replication of receive requests and forwarding of send requests.
//
//   channel   dir  beat fields (low bit up)
//   s_*       in   cmd, dest_addr, port_id, hop_limit, pkt_handle
//   m_*       out  action, out_port, out_handle; tlast marks final result
//
// each item: the table is read as the item is accepted, then the item is
// decoded and its table entry updated; results then leave through the single
// output register, one per cycle, and stall on m_tready; a receive gives up
// to MIN(NUM_PORTS,16) results, one more when NUM_PORTS < 16 and the ingress
// port lies outside the map; others at most one. After reset a sweep clears
// the table, no accepts; no new item is taken until all results are emitted
// ----------------------------------------------------------------------------
module ip_multicast_forward_table #(
  parameter int NUM_PORTS  = imfwd_pkg::NUM_PORTS_DEF,
  parameter int GROUP_BITS = imfwd_pkg::GROUP_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // cmd, dest_addr, port_id, hop_limit, pkt_handle, zero pad
  input  logic [imfwd_pkg::IN_DATA_W-1:0]  s_tdata,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // action, out_port, out_handle, zero pad
  output logic [imfwd_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic                             m_tlast
);
  import imfwd_pkg::*;

  imfwd_ctl_t ctl;
  imfwd_sts_t sts;

  imfwd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .ctl      (ctl)
  );

  imfwd_dp #(
    .NUM_PORTS  (NUM_PORTS),
    .GROUP_BITS (GROUP_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .ctl      (ctl),
    .sts      (sts)
  );

endmodule

/* sv/imfwd_chk.sv */
// ----------------------------------------------------------------------------
// imfwd_chk
// Port-level checks for the multicast forward table, bound to the top level.
// ----------------------------------------------------------------------------
module imfwd_chk (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_tready,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [imfwd_pkg::OUT_DATA_W-1:0] m_tdata,
  input logic                             m_tlast
);
  import imfwd_pkg::*;

  // table clear keeps the input closed right after reset
  a_clear_closed: assert property (@(posedge clk) rst |=> !s_tready && !m_tvalid)
    else $error("input open or result shown during table clear");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled result beat changed");

  a_action: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[OUT_ACT_LSB +: ACT_W] == ACT_DELIVER) ||
                 (m_tdata[OUT_ACT_LSB +: ACT_W] == ACT_TRANSMIT) ||
                 (m_tdata[OUT_ACT_LSB +: ACT_W] == ACT_ERROR))
    else $error("unknown action code");

  a_error_beat: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[OUT_ACT_LSB +: ACT_W] == ACT_ERROR)
      |-> m_tlast && (m_tdata[OUT_PORT_LSB +: PORT_W + HANDLE_W] == '0))
    else $error("error beat not single or not zeroed");

  // no new item while results of the current one are still to come
  a_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> !s_tready)
    else $error("input open while results remain");

endmodule

bind ip_multicast_forward_table imfwd_chk u_imfwd_chk (.*);

/* tb/ip_multicast_forward_table_tb.sv */
// ----------------------------------------------------------------------------
// ip_multicast_forward_table_tb
// Drives table updates, receives and sends through the input stream and
// checks every emitted beat against a behavioral copy of the group table,
// with bursty input and a patterned output stall.
// ----------------------------------------------------------------------------
module ip_multicast_forward_table_tb;
  import imfwd_pkg::*;

  localparam int NUM_PORTS  = NUM_PORTS_DEF;
  localparam int GROUP_BITS = GROUP_BITS_DEF;
  localparam int DEPTH      = 1 << GROUP_BITS;
  localparam int PORT_LIMIT = (NUM_PORTS < PORT_FIELD_LIMIT) ? NUM_PORTS : PORT_FIELD_LIMIT;
  localparam int RANDOM_ITEMS = 125;
  localparam int TAIL_CYCLES  = 40;
  localparam int MAX_PRINTS   = 60;

  localparam logic [CMD_W-1:0] CMD_UNUSED_6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_UNUSED_7 = 3'd7;

  typedef struct packed {
    logic [CMD_W-1:0]    cmd;
    logic [ADDR_W-1:0]   addr;
    logic [PORT_W-1:0]   port;
    logic [HOP_W-1:0]    hop;
    logic [HANDLE_W-1:0] handle;
  } request_t;

  typedef struct packed {
    logic [ACT_W-1:0]    action;
    logic [PORT_W-1:0]   port;
    logic [HANDLE_W-1:0] handle;
    logic                last;
  } egress_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tlast;

  request_t request_q[$];
  egress_t  egress_q[$];
  request_t cur_req;
  int       n_errors = 0;
  int       n_accepted = 0;
  int       n_queued = 0;
  int       burst_left = 1;
  int       gap_left = 0;
  int       rx_mode = 0;
  int       rx_phase = 0;

  logic [NUM_PORTS-1:0] fanout_map [DEPTH];
  logic                 member_on  [DEPTH];
  logic [PORT_W-1:0]    member_at  [DEPTH];

  ip_multicast_forward_table #(
    .NUM_PORTS  (NUM_PORTS),
    .GROUP_BITS (GROUP_BITS)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always #5 clk = ~clk;

  task automatic flag_mismatch(input string what);
    if (n_errors < MAX_PRINTS) $display("%0t: %s", $realtime, what);
    n_errors++;
  endtask

  function automatic logic [IN_DATA_W-1:0] pack_request(input request_t r);
    logic [IN_DATA_W-1:0] d;
    d = '0;
    d[IN_CMD_LSB +: CMD_W]       = r.cmd;
    d[IN_ADDR_LSB +: ADDR_W]     = r.addr;
    d[IN_PORT_LSB +: PORT_W]     = r.port;
    d[IN_HOP_LSB +: HOP_W]       = r.hop;
    d[IN_HANDLE_LSB +: HANDLE_W] = r.handle;
    return d;
  endfunction

  // updates the table copy and queues the beats this request produces
  function automatic void route_request(input request_t r);
    logic [GROUP_BITS-1:0] g;
    egress_t copies[$];
    egress_t e;
    g = r.addr[GROUP_BITS-1:0];
    if (r.cmd == CMD_UNUSED_6 || r.cmd == CMD_UNUSED_7) return;
    if (r.addr[ADDR_W-1 -: 4] != MCAST_PREFIX) begin
      if (r.cmd != CMD_RECEIVE && r.cmd != CMD_SEND)
        egress_q.push_back('{ACT_ERROR, '0, '0, 1'b1});
      return;
    end
    case (r.cmd)
      CMD_RECEIVE: begin
        if (member_on[g]) copies.push_back('{ACT_DELIVER, r.port, r.handle, 1'b0});
        if (r.hop != '0) begin
          for (int p = 0; p < PORT_LIMIT; p++) begin
            if (p != r.port && fanout_map[g][p])
              copies.push_back('{ACT_TRANSMIT, PORT_W'(p), r.handle, 1'b0});
          end
        end
        if (copies.size() != 0) begin
          e = copies.pop_back();
          e.last = 1'b1;
          copies.push_back(e);
        end
        foreach (copies[i]) egress_q.push_back(copies[i]);
      end
      CMD_SEND: begin
        if (member_on[g]) egress_q.push_back('{ACT_TRANSMIT, member_at[g], r.handle, 1'b1});
      end
      CMD_JOIN: begin
        if (r.port < PORT_LIMIT) fanout_map[g][r.port] = 1'b1;
      end
      CMD_LEAVE: begin
        if (r.port < PORT_LIMIT) fanout_map[g][r.port] = 1'b0;
      end
      CMD_LOCAL_JOIN: begin
        member_on[g] = 1'b1;
        member_at[g] = r.port;
      end
      CMD_LOCAL_LEAVE: begin
        member_on[g] = 1'b0;
        member_at[g] = '0;
      end
      default: ;
    endcase
  endfunction

  function automatic void push_req(input logic [CMD_W-1:0] c, input logic [ADDR_W-1:0] a,
                                   input logic [PORT_W-1:0] p, input logic [HOP_W-1:0] h,
                                   input logic [HANDLE_W-1:0] d);
    request_q.push_back('{c, a, p, h, d});
  endfunction

  function automatic logic [ADDR_W-1:0] group_addr(input logic [GROUP_BITS-1:0] g);
    logic [ADDR_W-1:0] a;
    a = $urandom;
    a[ADDR_W-1 -: 4] = MCAST_PREFIX;
    a[GROUP_BITS-1:0] = g;
    return a;
  endfunction

  function automatic logic [ADDR_W-1:0] plain_addr();
    logic [ADDR_W-1:0] a;
    a = $urandom;
    if (a[ADDR_W-1 -: 4] == MCAST_PREFIX) a[ADDR_W-4] = 1'b1;
    return a;
  endfunction

  function automatic logic [HOP_W-1:0] pick_hop();
    if ($urandom_range(0, 9) == 0) return '0;
    return HOP_W'($urandom_range(1, 255));
  endfunction

  // input driver: bursts of random length with random gaps
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid   <= 1'b0;
      s_tdata    <= '0;
      burst_left = 1;
      gap_left   = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        route_request(cur_req);
        n_accepted++;
      end
      if (!s_tvalid || s_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (request_q.size() != 0) begin
          cur_req = request_q.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= pack_request(cur_req);
          if (burst_left > 1) begin
            burst_left--;
          end else if ($urandom_range(0, 3) == 0) begin
            burst_left = 32;
            gap_left   = 0;
          end else begin
            burst_left = $urandom_range(1, 6);
            gap_left   = $urandom_range(0, 5);
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // output monitor and stall pattern
  always @(posedge clk) begin
    egress_t want;
    if (rst) begin
      m_tready <= 1'b0;
      rx_phase = 0;
      rx_mode  = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (egress_q.size() == 0) begin
          flag_mismatch("result beat with nothing expected");
        end else begin
          want = egress_q.pop_front();
          if (m_tdata[OUT_ACT_LSB +: ACT_W] != want.action)
            flag_mismatch($sformatf("action %0d, expected %0d",
                                    m_tdata[OUT_ACT_LSB +: ACT_W], want.action));
          if (m_tdata[OUT_PORT_LSB +: PORT_W] != want.port)
            flag_mismatch($sformatf("out_port %0d, expected %0d",
                                    m_tdata[OUT_PORT_LSB +: PORT_W], want.port));
          if (m_tdata[OUT_HANDLE_LSB +: HANDLE_W] != want.handle)
            flag_mismatch($sformatf("out_handle %h, expected %h",
                                    m_tdata[OUT_HANDLE_LSB +: HANDLE_W], want.handle));
          if (m_tlast != want.last)
            flag_mismatch($sformatf("tlast %0d, expected %0d", m_tlast, want.last));
        end
      end
      rx_phase++;
      if (rx_phase % 50 == 0) rx_mode = $urandom_range(0, 3);
      case (rx_mode)
        0: m_tready <= 1'b1;
        1: m_tready <= rx_phase[0];
        2: m_tready <= ($urandom_range(0, 3) != 0);
        default: m_tready <= ((rx_phase % 7) >= 3);
      endcase
    end
  end

  initial begin
    logic [GROUP_BITS-1:0] pool [4];
    logic [GROUP_BITS-1:0] g;
    logic [ADDR_W-1:0]     ga;
    logic [CMD_W-1:0]      c;
    int                    n_random;
    int                    kind;
    int                    pick;

    for (int i = 0; i < DEPTH; i++) begin
      fanout_map[i] = '0;
      member_on[i]  = 1'b0;
      member_at[i]  = '0;
    end

    // directed: empty table, non-multicast cases, unused codes, fan-out basics
    ga = group_addr('1);
    push_req(CMD_RECEIVE, 32'hE000_0000, 4'd0, 8'd255, 16'h0000);
    push_req(CMD_SEND, 32'hEFFF_FFFF, 4'd15, 8'd1, 16'hFFFF);
    push_req(CMD_JOIN, 32'h0000_0000, 4'd0, 8'd0, 16'h0000);
    push_req(CMD_LEAVE, 32'hFFFF_FFFF, 4'd15, 8'd255, 16'hFFFF);
    push_req(CMD_LOCAL_JOIN, 32'hDFFF_FFFF, 4'd7, 8'd3, 16'h1234);
    push_req(CMD_LOCAL_LEAVE, 32'hF000_0000, 4'd8, 8'd4, 16'h5678);
    push_req(CMD_RECEIVE, 32'h7F00_0001, 4'd2, 8'd64, 16'hABCD);
    push_req(CMD_SEND, 32'hC0A8_0001, 4'd3, 8'd64, 16'hBEEF);
    push_req(CMD_UNUSED_6, ga, 4'd1, 8'd1, 16'h0001);
    push_req(CMD_UNUSED_7, 32'h1234_5678, 4'd1, 8'd1, 16'h0002);
    push_req(CMD_JOIN, ga, 4'd0, 8'd0, 16'h0000);
    push_req(CMD_JOIN, ga, 4'd15, 8'd0, 16'h0000);
    push_req(CMD_JOIN, ga, 4'd3, 8'd0, 16'h0000);
    push_req(CMD_JOIN, ga, 4'd7, 8'd0, 16'h0000);
    push_req(CMD_LOCAL_JOIN, ga, 4'd9, 8'd0, 16'h0000);
    push_req(CMD_RECEIVE, ga, 4'd3, 8'd255, 16'hFFFF);
    push_req(CMD_RECEIVE, ga, 4'd5, 8'd0, 16'h00A5);
    push_req(CMD_SEND, ga, 4'd2, 8'd9, 16'h5A5A);
    push_req(CMD_LEAVE, ga, 4'd3, 8'd0, 16'h0000);
    push_req(CMD_LEAVE, ga, 4'd15, 8'd0, 16'h0000);
    push_req(CMD_LEAVE, ga, 4'd12, 8'd0, 16'h0000);
    push_req(CMD_LOCAL_LEAVE, ga, 4'd6, 8'd0, 16'h0000);
    push_req(CMD_RECEIVE, ga, 4'd0, 8'd1, 16'h0F0F);
    push_req(CMD_SEND, ga, 4'd0, 8'd1, 16'hF0F0);
    push_req(CMD_RECEIVE, ga, 4'd7, 8'd1, 16'h8001);

    // random: mostly traffic on a few live groups, some full fan-outs and noise
    foreach (pool[i]) pool[i] = GROUP_BITS'($urandom);
    n_random = 0;
    while (n_random < RANDOM_ITEMS) begin
      kind = $urandom_range(0, 99);
      if (kind < 3) begin
        g = pool[$urandom_range(0, 3)];
        for (int p = 0; p < PORT_LIMIT; p++)
          push_req(CMD_JOIN, group_addr(g), PORT_W'(p), pick_hop(), HANDLE_W'($urandom));
        push_req(CMD_LOCAL_JOIN, group_addr(g), PORT_W'($urandom), pick_hop(),
                 HANDLE_W'($urandom));
        push_req(CMD_RECEIVE, group_addr(g), PORT_W'($urandom),
                 HOP_W'($urandom_range(1, 255)), HANDLE_W'($urandom));
        n_random += PORT_LIMIT + 2;
      end else if (kind < 10) begin
        c = ($urandom_range(0, 1) == 0) ? CMD_UNUSED_6 : CMD_UNUSED_7;
        push_req(c, $urandom, PORT_W'($urandom), HOP_W'($urandom), HANDLE_W'($urandom));
        n_random++;
      end else if (kind < 22) begin
        push_req(CMD_W'($urandom_range(0, 5)), plain_addr(), PORT_W'($urandom), pick_hop(),
                 HANDLE_W'($urandom));
        n_random++;
      end else begin
        g = ($urandom_range(0, 9) == 0) ? GROUP_BITS'($urandom) : pool[$urandom_range(0, 3)];
        pick = $urandom_range(0, 99);
        if (pick < 35)      c = CMD_RECEIVE;
        else if (pick < 45) c = CMD_SEND;
        else if (pick < 70) c = CMD_JOIN;
        else if (pick < 80) c = CMD_LEAVE;
        else if (pick < 92) c = CMD_LOCAL_JOIN;
        else                c = CMD_LOCAL_LEAVE;
        push_req(c, group_addr(g), PORT_W'($urandom), pick_hop(), HANDLE_W'($urandom));
        n_random++;
      end
    end
    n_queued = request_q.size();

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (n_accepted < n_queued) @(posedge clk);
    while (egress_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (n_errors == 0) begin
      $display("ip_multicast_forward_table: match");
    end else begin
      $display("ip_multicast_forward_table: mismatch");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("ip_multicast_forward_table: mismatch");
    $finish;
  end

endmodule
